// File: rtl/fcs_pkg.sv
// ----------------------------------------------------------------------------
// fcs_pkg
// Types and constants shared by the FABRIK chain solver.
// ----------------------------------------------------------------------------
package fcs_pkg;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vec;

    localparam logic        OP_LOAD  = 1'b0;
    localparam logic        OP_SOLVE = 1'b1;

    localparam logic [1:0]  CFG_CHAIN_LEN = 2'd0;
    localparam logic [1:0]  CFG_MAX_ITER  = 2'd1;

    // unit vector component of length one, Q1.30
    localparam logic [30:0] UNIT_ONE = 31'h4000_0000;

    localparam logic [4:0]  SQRT_LAST = 5'd31;
    localparam logic [4:0]  DIV_LAST  = 5'd30;
    localparam logic [1:0]  AXIS_LAST = 2'd2;

    function automatic logic signed [31:0] vget(input t_vec v, input logic [1:0] k);
        logic signed [31:0] c;
        unique case (k)
            2'd1:    c = v.y;
            2'd2:    c = v.z;
            default: c = v.x;
        endcase
        return c;
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] d);
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

endpackage

// File: rtl/fabrik_chain_solver.sv
// ----------------------------------------------------------------------------
// fabrik_chain_solver
// FABRIK inverse kinematics on a chain of up to MAX_JOINTS joints, Q16.16.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): op 0 stores a joint position in
// slot joint_index; op 1 solves the stored chain toward the target pos_x/y/z.
// A load is stored when accepted. A solve emits one item per joint on the output
// channel (o_out_valid / i_out_stall), root first, with o_last on the tip.
// Configuration (i_cfg_valid / o_cfg_ready) is always ready and sets
// chain_length and max_iterations; write it only while the block is idle.
// All vector math runs on one shared datapath: a 32x32 multiplier, a
// bit-serial square root and a bit-serial divider used once per axis.
// A reachable target takes max_iterations backward and forward passes
// (at least one); for an unreachable one, a single pass stretches each
// joint toward the target from the joint before it.
// o_in_stall is high from the solve item until its last result is loaded
// into the output register; a stalled receiver holds the solver there.
// Reset clears the control state and sets chain_length 2, max_iterations 10.
// Joint slots hold nothing defined until loaded.
// ----------------------------------------------------------------------------
module fabrik_chain_solver
    import fcs_pkg::*;
#(
    parameter int MAX_JOINTS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic [2:0]         i_joint_index,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_out_index,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    localparam int IW = $clog2(MAX_JOINTS);
    localparam int NW = $clog2(MAX_JOINTS + 1);
    localparam int TW = 34 + IW;

    typedef enum logic [4:0] {
        S_IDLE, S_CRD, S_CWR, S_FA, S_FB, S_FC, S_DIF, S_MAG, S_SQ, S_ACC,
        S_SQRT, S_NRM, S_LEN, S_DIVI, S_DIV, S_MUL, S_ADD, S_WB, S_TIP,
        S_PIN, S_ORD, S_OLD
    } t_st;

    typedef enum logic [2:0] {
        PH_SEG, PH_REACH, PH_STR, PH_BWD, PH_FWD
    } t_ph;

    t_st                r_st;
    t_ph                r_ph;
    logic [3:0]         r_cfg_len;
    logic [7:0]         r_cfg_iter;
    logic [NW-1:0]      r_n;
    logic [7:0]         r_iters;
    logic [7:0]         r_it;
    logic [IW-1:0]      r_i;
    logic [1:0]         r_k;
    logic [4:0]         r_cnt;
    logic [TW-1:0]      r_total;
    t_vec               r_tgt, r_root, r_base, r_tow, r_jrd, r_wrd;
    logic [31:0]        r_len, r_srd;
    logic signed [32:0] r_d [3];
    logic [31:0]        r_ax [3];
    logic               r_sh;
    logic [63:0]        r_prod, r_acc, r_x, r_r, r_bit;
    logic [32:0]        r_nlen;
    logic [32:0]        r_rem;
    logic               r_inb, r_cap;
    logic [30:0]        r_q;
    logic signed [31:0] r_res [3];
    logic               r_ov, r_olast;
    logic [2:0]         r_oidx;
    t_vec               r_ovec;

    t_vec               jmem [MAX_JOINTS];
    t_vec               wmem [MAX_JOINTS];
    logic [31:0]        smem [MAX_JOINTS];

    logic               w_in_acc;
    logic [IW-1:0]      w_ip1, w_nm1, w_base_idx, w_tow_idx, w_dst_idx, w_raddr;
    logic               w_last_seg, w_tow_tgt;
    logic               w_we;
    logic [IW-1:0]      w_waddr;
    t_vec               w_wdata;
    logic [32:0]        w_mag [3];
    logic               w_big;
    logic [32:0]        w_magk;
    logic [31:0]        w_ma, w_mb;
    logic [63:0]        w_t;
    logic [33:0]        w_rem2;
    logic               w_dge;
    logic [30:0]        w_u;
    logic [32:0]        w_off;
    logic signed [31:0] w_bk;
    logic signed [33:0] w_sum;
    logic signed [31:0] w_sat;
    logic [31:0]        w_lsat;
    logic [NW-1:0]      w_ncl;

    assign o_in_stall  = (r_st != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && !o_in_stall;

    assign w_ip1      = IW'(r_i + 1'b1);
    assign w_nm1      = IW'(r_n - 1'b1);
    assign w_last_seg = (NW'(r_i) == NW'(r_n - NW'(2)));
    assign w_tow_tgt  = (r_ph == PH_REACH) || (r_ph == PH_STR);
    assign w_base_idx = (r_ph == PH_BWD) ? w_ip1 : ((r_ph == PH_REACH) ? '0 : r_i);
    assign w_tow_idx  = (r_ph == PH_BWD) ? r_i : w_ip1;
    assign w_dst_idx  = (r_ph == PH_BWD) ? r_i : w_ip1;

    always_comb begin
        unique case (r_st)
            S_FA:    w_raddr = w_base_idx;
            S_FB:    w_raddr = w_tow_idx;
            default: w_raddr = r_i;
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_i;
        w_wdata = r_jrd;
        unique case (r_st)
            S_CWR: begin
                w_we = 1'b1;
            end
            S_WB: begin
                w_we    = 1'b1;
                w_waddr = w_dst_idx;
                w_wdata = '{x: r_res[0], y: r_res[1], z: r_res[2]};
            end
            S_TIP: begin
                w_we    = 1'b1;
                w_waddr = w_nm1;
                w_wdata = r_tgt;
            end
            S_PIN: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = r_root;
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_mag[k] = mag33(r_d[k]);
        end
        w_big  = (w_mag[0][32:31] != 2'b00) || (w_mag[1][32:31] != 2'b00) ||
                 (w_mag[2][32:31] != 2'b00);
        w_magk = w_mag[r_k];
    end

    assign w_u  = (r_cap || (r_q > UNIT_ONE)) ? UNIT_ONE : r_q;
    assign w_ma = (r_st == S_SQ) ? r_ax[r_k] : {1'b0, w_u};
    assign w_mb = (r_st == S_SQ) ? r_ax[r_k] : r_len;

    assign w_t    = r_r + r_bit;
    assign w_rem2 = {r_rem, r_inb};
    assign w_dge  = (w_rem2 >= {1'b0, r_nlen});

    assign w_off = r_prod[62:30];
    assign w_bk  = vget(r_base, r_k);
    assign w_sum = r_d[r_k][32] ? (34'(w_bk) - $signed({1'b0, w_off}))
                                : (34'(w_bk) + $signed({1'b0, w_off}));
    always_comb begin
        if (w_sum[33:31] == 3'b000 || w_sum[33:31] == 3'b111) begin
            w_sat = w_sum[31:0];
        end else begin
            w_sat = w_sum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    assign w_lsat = r_nlen[32] ? 32'hFFFF_FFFF : r_nlen[31:0];

    always_comb begin
        if (r_cfg_len < 4'd2) begin
            w_ncl = NW'(2);
        end else if (32'(r_cfg_len) > MAX_JOINTS) begin
            w_ncl = NW'(MAX_JOINTS);
        end else begin
            w_ncl = NW'(r_cfg_len);
        end
    end

    // joint store, loaded by op 0
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_op == OP_LOAD && 32'(i_joint_index) < MAX_JOINTS) begin
            jmem[IW'(i_joint_index)] <= '{x: i_pos_x, y: i_pos_y, z: i_pos_z};
        end
        r_jrd <= jmem[r_i];
    end

    // working positions during a solve
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            wmem[w_waddr] <= w_wdata;
        end
        r_wrd <= wmem[w_raddr];
    end

    // segment lengths
    always_ff @(posedge i_clk) begin
        if (r_st == S_LEN && r_ph == PH_SEG) begin
            smem[r_i] <= w_lsat;
        end
        r_srd <= smem[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= S_IDLE;
            r_ph       <= PH_SEG;
            r_cfg_len  <= 4'd2;
            r_cfg_iter <= 8'd10;
            r_ov       <= 1'b0;
            r_i        <= '0;
            r_k        <= '0;
            r_cnt      <= '0;
            r_it       <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CHAIN_LEN: r_cfg_len  <= i_cfg_data[3:0];
                    CFG_MAX_ITER:  r_cfg_iter <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ov && !i_out_stall && r_st != S_OLD) begin
                r_ov <= 1'b0;
            end

            unique case (r_st)
                S_IDLE: begin
                    if (w_in_acc && i_op == OP_SOLVE) begin
                        r_tgt   <= '{x: i_pos_x, y: i_pos_y, z: i_pos_z};
                        r_n     <= w_ncl;
                        r_iters <= (r_cfg_iter == 8'd0) ? 8'd1 : r_cfg_iter;
                        r_i     <= '0;
                        r_ph    <= PH_SEG;
                        r_st    <= S_CRD;
                    end
                end
                S_CRD: r_st <= S_CWR;
                S_CWR: begin
                    if (r_i == '0) begin
                        r_root <= r_jrd;
                    end
                    if (r_i == w_nm1) begin
                        r_i     <= '0;
                        r_ph    <= PH_SEG;
                        r_total <= '0;
                        r_st    <= S_FA;
                    end else begin
                        r_i  <= w_ip1;
                        r_st <= S_CRD;
                    end
                end
                S_FA: r_st <= S_FB;
                S_FB: begin
                    r_base <= r_wrd;
                    r_st   <= S_FC;
                end
                S_FC: begin
                    r_tow <= w_tow_tgt ? r_tgt : r_wrd;
                    r_len <= r_srd;
                    r_st  <= S_DIF;
                end
                S_DIF: begin
                    r_d[0] <= 33'(r_tow.x) - 33'(r_base.x);
                    r_d[1] <= 33'(r_tow.y) - 33'(r_base.y);
                    r_d[2] <= 33'(r_tow.z) - 33'(r_base.z);
                    r_st   <= S_MAG;
                end
                S_MAG: begin
                    for (int k = 0; k < 3; k++) begin
                        r_ax[k] <= w_big ? w_mag[k][32:1] : w_mag[k][31:0];
                    end
                    r_sh  <= w_big;
                    r_acc <= '0;
                    r_k   <= '0;
                    r_st  <= S_SQ;
                end
                S_SQ: begin
                    r_prod <= w_ma * w_mb;
                    r_st   <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= r_acc + r_prod;
                    if (r_k == AXIS_LAST) begin
                        r_x   <= r_acc + r_prod;
                        r_r   <= '0;
                        r_bit <= 64'h4000_0000_0000_0000;
                        r_cnt <= '0;
                        r_st  <= S_SQRT;
                    end else begin
                        r_k  <= r_k + 2'd1;
                        r_st <= S_SQ;
                    end
                end
                S_SQRT: begin
                    if (r_x >= w_t) begin
                        r_x <= r_x - w_t;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == SQRT_LAST) begin
                        r_st <= S_NRM;
                    end
                end
                S_NRM: begin
                    r_nlen <= r_sh ? {r_r[31:0], 1'b0} : {1'b0, r_r[31:0]};
                    r_st   <= S_LEN;
                end
                S_LEN: begin
                    priority case (r_ph)
                        PH_SEG: begin
                            r_total <= r_total + TW'(w_lsat);
                            if (w_last_seg) begin
                                r_ph <= PH_REACH;
                            end else begin
                                r_i <= w_ip1;
                            end
                            r_st <= S_FA;
                        end
                        PH_REACH: begin
                            r_it <= '0;
                            if (TW'(r_nlen) > r_total) begin
                                r_ph <= PH_STR;
                                r_i  <= '0;
                                r_st <= S_FA;
                            end else begin
                                r_st <= S_TIP;
                            end
                        end
                        default: begin
                            if (r_nlen == '0) begin
                                r_res[0] <= r_base.x;
                                r_res[1] <= r_base.y;
                                r_res[2] <= r_base.z;
                                r_st     <= S_WB;
                            end else begin
                                r_k  <= '0;
                                r_st <= S_DIVI;
                            end
                        end
                    endcase
                end
                S_DIVI: begin
                    r_cap <= ({1'b0, w_magk} >= {r_nlen, 1'b0});
                    r_rem <= w_magk >> 1;
                    r_inb <= w_magk[0];
                    r_q   <= '0;
                    r_cnt <= '0;
                    r_st  <= ({1'b0, w_magk} >= {r_nlen, 1'b0}) ? S_MUL : S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_dge ? 33'(w_rem2 - {1'b0, r_nlen}) : w_rem2[32:0];
                    r_q   <= {r_q[29:0], w_dge};
                    r_inb <= 1'b0;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_st <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= w_ma * w_mb;
                    r_st   <= S_ADD;
                end
                S_ADD: begin
                    r_res[r_k] <= w_sat;
                    if (r_k == AXIS_LAST) begin
                        r_st <= S_WB;
                    end else begin
                        r_k  <= r_k + 2'd1;
                        r_st <= S_DIVI;
                    end
                end
                S_WB: begin
                    priority case (r_ph)
                        PH_BWD: begin
                            if (r_i == '0) begin
                                r_st <= S_PIN;
                            end else begin
                                r_i  <= IW'(r_i - 1'b1);
                                r_st <= S_FA;
                            end
                        end
                        PH_FWD: begin
                            if (!w_last_seg) begin
                                r_i  <= w_ip1;
                                r_st <= S_FA;
                            end else if (r_it == r_iters - 8'd1) begin
                                r_i  <= '0;
                                r_st <= S_ORD;
                            end else begin
                                r_it <= r_it + 8'd1;
                                r_st <= S_TIP;
                            end
                        end
                        default: begin
                            if (w_last_seg) begin
                                r_i  <= '0;
                                r_st <= S_ORD;
                            end else begin
                                r_i  <= w_ip1;
                                r_st <= S_FA;
                            end
                        end
                    endcase
                end
                S_TIP: begin
                    r_ph <= PH_BWD;
                    r_i  <= IW'(r_n - NW'(2));
                    r_st <= S_FA;
                end
                S_PIN: begin
                    r_ph <= PH_FWD;
                    r_i  <= '0;
                    r_st <= S_FA;
                end
                S_ORD: r_st <= S_OLD;
                S_OLD: begin
                    if (!r_ov || !i_out_stall) begin
                        r_ov    <= 1'b1;
                        r_ovec  <= r_wrd;
                        r_oidx  <= 3'(r_i);
                        r_olast <= (r_i == w_nm1);
                        if (r_i == w_nm1) begin
                            r_st <= S_IDLE;
                        end else begin
                            r_i  <= w_ip1;
                            r_st <= S_ORD;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_index = r_oidx;
    assign o_out_x     = r_ovec.x;
    assign o_out_y     = r_ovec.y;
    assign o_out_z     = r_ovec.z;
    assign o_last      = r_olast;

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_DIV) |-> (r_rem < r_nlen))
        else $error("divider remainder not below divisor");

    a_sqrt_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_NRM) |-> (r_r[63:32] == 32'd0))
        else $error("square root wider than 32 bits");

    a_joint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE && r_st != S_CRD && r_st != S_CWR) |-> (NW'(r_i) < r_n))
        else $error("joint counter beyond chain");

    a_iter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE && (r_ph == PH_BWD || r_ph == PH_FWD)) |-> (r_it < r_iters))
        else $error("pass counter beyond limit");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OLD && (!r_ov || !i_out_stall) && r_i == w_nm1) |=>
            (r_st == S_IDLE && o_last))
        else $error("tip item did not end the solve");

endmodule

// File: tb/fcs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fcs_checker
// Watches the load/solve, result and register channels of the chain solver,
// predicts every solved joint position and compares each result field by field.
// ----------------------------------------------------------------------------
module fcs_checker
    import fcs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_op,
    input  logic [2:0]         i_joint_index,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [2:0]         i_out_index,
    input  logic signed [31:0] i_out_x,
    input  logic signed [31:0] i_out_y,
    input  logic signed [31:0] i_out_z,
    input  logic               i_last,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int                   JOINTS   = 8;
    localparam longint unsigned      UNIT_Q30 = 64'h4000_0000;

    typedef struct {
        logic [2:0]         idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
    } t_joint_pos;

    t_joint_pos        solved_q[$];
    logic [3:0]        chain_len;
    logic [7:0]        iter_cnt;
    longint            stored[JOINTS][3];
    longint            work[JOINTS][3];
    longint unsigned   seg_len[JOINTS];
    int                errors;

    function automatic longint unsigned mag_u(longint v);
        return (v < 0) ? longint'(0 - v) : v;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned isqrt_u(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned span_len(longint dx, longint dy, longint dz);
        longint unsigned ax, ay, az;
        int sh;
        ax = mag_u(dx);
        ay = mag_u(dy);
        az = mag_u(dz);
        sh = 0;
        if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000 || az >= 64'h8000_0000) begin
            sh = 1;
            ax = ax >> 1;
            ay = ay >> 1;
            az = az >> 1;
        end
        return isqrt_u(ax * ax + ay * ay + az * az) << sh;
    endfunction

    function automatic longint step_axis(longint base, longint d, longint unsigned nrm,
                                         longint unsigned len);
        longint unsigned u, off;
        u = (mag_u(d) << 30) / nrm;
        if (u > UNIT_Q30) u = UNIT_Q30;
        off = (u * len) >> 30;
        if (d < 0) return sat32(base - longint'(off));
        return sat32(base + longint'(off));
    endfunction

    // work[dst] = work[b] + unit(t - work[b]) * len
    function automatic void move_joint(int dst, int b, longint tx, longint ty, longint tz,
                                       longint unsigned len);
        longint d[3];
        longint unsigned nrm;
        d[0] = tx - work[b][0];
        d[1] = ty - work[b][1];
        d[2] = tz - work[b][2];
        nrm = span_len(d[0], d[1], d[2]);
        for (int k = 0; k < 3; k++) begin
            if (nrm == 0) work[dst][k] = work[b][k];
            else work[dst][k] = step_axis(work[b][k], d[k], nrm, len);
        end
    endfunction

    function automatic void predict_solve(longint tx, longint ty, longint tz);
        int n;
        int iters;
        longint unsigned total, l;
        longint root[3];
        t_joint_pos r;
        n = int'(chain_len);
        if (n < 2) n = 2;
        if (n > JOINTS) n = JOINTS;
        iters = (iter_cnt == 0) ? 1 : int'(iter_cnt);
        for (int i = 0; i < n; i++)
            for (int k = 0; k < 3; k++) work[i][k] = stored[i][k];
        total = 0;
        for (int i = 0; i < n - 1; i++) begin
            l = span_len(work[i+1][0] - work[i][0], work[i+1][1] - work[i][1],
                         work[i+1][2] - work[i][2]);
            if (l > 64'hFFFF_FFFF) l = 64'hFFFF_FFFF;
            seg_len[i] = l;
            total += l;
        end
        for (int k = 0; k < 3; k++) root[k] = work[0][k];
        if (span_len(tx - root[0], ty - root[1], tz - root[2]) > total) begin
            for (int i = 0; i < n - 1; i++) move_joint(i + 1, i, tx, ty, tz, seg_len[i]);
        end else begin
            for (int it = 0; it < iters; it++) begin
                work[n-1][0] = tx;
                work[n-1][1] = ty;
                work[n-1][2] = tz;
                for (int i = n - 2; i >= 0; i--)
                    move_joint(i, i + 1, work[i][0], work[i][1], work[i][2], seg_len[i]);
                for (int k = 0; k < 3; k++) work[0][k] = root[k];
                for (int i = 0; i < n - 1; i++)
                    move_joint(i + 1, i, work[i+1][0], work[i+1][1], work[i+1][2],
                               seg_len[i]);
            end
        end
        for (int i = 0; i < n; i++) begin
            r.idx  = 3'(i);
            r.x    = work[i][0][31:0];
            r.y    = work[i][1][31:0];
            r.z    = work[i][2][31:0];
            r.last = (i == n - 1);
            solved_q.insert(solved_q.size(), r);
        end
    endfunction

    initial begin
        errors = 0;
    end

    always @(posedge i_clk) begin
        t_joint_pos e;
        if (!i_rst_n) begin
            chain_len <= 4'd2;
            iter_cnt  <= 8'd10;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (solved_q.size() == 0) begin
                    errors++;
                    $display("%0t: result idx %0d with no solve pending", $time, i_out_index);
                end else begin
                    e = solved_q.pop_front();
                    if (i_out_index !== e.idx || i_out_x !== e.x || i_out_y !== e.y ||
                        i_out_z !== e.z || i_last !== e.last) begin
                        errors++;
                        $display("%0t: mismatch exp idx %0d (%h %h %h) last %b", $time,
                                 e.idx, e.x, e.y, e.z, e.last);
                        $display("%0t:          got idx %0d (%h %h %h) last %b", $time,
                                 i_out_index, i_out_x, i_out_y, i_out_z, i_last);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_CHAIN_LEN) chain_len <= i_cfg_data[3:0];
                else if (i_cfg_index == CFG_MAX_ITER) iter_cnt <= i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_op == OP_LOAD) begin
                    stored[i_joint_index][0] = longint'(i_pos_x);
                    stored[i_joint_index][1] = longint'(i_pos_y);
                    stored[i_joint_index][2] = longint'(i_pos_z);
                end else begin
                    predict_solve(longint'(i_pos_x), longint'(i_pos_y), longint'(i_pos_z));
                end
            end
        end
        o_errors  <= errors;
        o_pending <= solved_q.size();
    end

endmodule

// File: tb/tb_fabrik_chain_solver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fabrik_chain_solver
// Drives joint loads and solves through several chain length and iteration
// settings with random gaps and result stalls; the checker judges results.
// ----------------------------------------------------------------------------
module tb_fabrik_chain_solver;
    import fcs_pkg::*;

    localparam int CYCLE_LIMIT = 20_000_000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_op;
    logic [2:0]         i_joint_index;
    logic signed [31:0] i_pos_x;
    logic signed [31:0] i_pos_y;
    logic signed [31:0] i_pos_z;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [2:0]         o_out_index;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [31:0] o_out_z;
    logic               o_last;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [7:0]         i_cfg_data;
    int                 errors;
    int                 pending;
    int                 cycles;
    bit                 no_idle;

    fabrik_chain_solver dut (.*);

    fcs_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_op, .i_joint_index,
        .i_pos_x, .i_pos_y, .i_pos_z, .i_out_valid(o_out_valid), .i_out_stall,
        .i_out_index(o_out_index), .i_out_x(o_out_x), .i_out_y(o_out_y),
        .i_out_z(o_out_z), .i_last(o_last), .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 11);
    endfunction

    // result side stall
    initial begin
        int k;
        i_out_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            k = draw_gap();
            if (k > 0) begin
                i_out_stall <= 1'b1;
                repeat (k) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_item(logic op, logic [2:0] idx, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z);
        int g;
        g = draw_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_joint_index <= idx;
        i_pos_x       <= x;
        i_pos_y       <= y;
        i_pos_z       <= z;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    endfunction

    task automatic load_rand(logic [2:0] idx);
        send_item(OP_LOAD, idx, rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic solve_rand();
        if ($urandom_range(0, 3) == 0)
            send_item(OP_SOLVE, 3'd0, $urandom, $urandom, $urandom);
        else
            send_item(OP_SOLVE, 3'd0, rand_coord(), rand_coord(), rand_coord());
    endtask

    initial begin
        logic [7:0] cfg_list [5][2];
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_op          = OP_LOAD;
        i_joint_index = '0;
        i_pos_x       = '0;
        i_pos_y       = '0;
        i_pos_z       = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_CHAIN_LEN;
        i_cfg_data    = '0;
        no_idle       = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: extreme coordinates, saturated segment, zero vectors
        send_item(OP_LOAD, 3'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(OP_LOAD, 3'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        for (int i = 2; i < 8; i++) load_rand(3'(i));
        send_item(OP_SOLVE, 3'd7, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_item(OP_SOLVE, 3'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_LOAD, 3'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(OP_SOLVE, 3'd0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000);
        send_item(OP_SOLVE, 3'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(OP_LOAD, 3'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_item(OP_LOAD, 3'd1, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
        send_item(OP_SOLVE, 3'd0, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
        drain();

        cfg_list = '{'{8'd8, 8'd1}, '{8'd2, 8'd255}, '{8'd0, 8'd0}, '{8'd15, 8'd2},
                     '{8'hF3, 8'd3}};
        foreach (cfg_list[p]) begin
            write_reg(CFG_CHAIN_LEN, cfg_list[p][0]);
            write_reg(CFG_MAX_ITER, cfg_list[p][1]);
            load_rand(3'($urandom_range(0, 7)));
            solve_rand();
            solve_rand();
            drain();
        end

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_CHAIN_LEN, 8'($urandom_range(2, 5) + (ph == 7 ? 3 : 0)));
            write_reg(CFG_MAX_ITER, 8'($urandom_range(1, 3)));
            no_idle = (ph % 3 == 1);
            for (int k = 0; k < 40; k++) begin
                if ($urandom_range(0, 9) < 7) load_rand(3'($urandom_range(0, 7)));
                else solve_rand();
                if (ph == 3 && k == 20) drain();
            end
            drain();
        end
        no_idle = 1'b0;

        drain();
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
